// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by fast_exp_neg_approx, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/fenp_pkg.sv -----
// ---------------------------------------------------------------------------
// fenp_pkg
// types, constants and single-precision helper functions for the exp unit
// ---------------------------------------------------------------------------
package fenp_pkg;

    localparam int NUM_CFG = 8;

    localparam int CFG_LN2     = 0;
    localparam int CFG_INV_LN2 = 1;
    localparam int CFG_C0      = 2;
    localparam int CFG_C1      = 3;
    localparam int CFG_C2      = 4;
    localparam int CFG_C3      = 5;
    localparam int CFG_C4      = 6;
    localparam int CFG_C5      = 7;

    localparam int HORNER_STEPS = 5;

    localparam logic [31:0] CFG_RESET [NUM_CFG] = '{
        32'h3F317218, 32'h3FB8AA3B, 32'h3F800000, 32'h3F800000,
        32'h3F000000, 32'h3E2AAAAB, 32'h3D2AAAAB, 32'h3C088889
    };

    localparam logic [31:0] POS_LIMIT = 32'h42AE0000;
    localparam logic [31:0] NEG_LIMIT = 32'hC2AE0000;
    localparam logic [31:0] QNAN_DEF  = 32'hFFC00000;
    localparam logic [31:0] QUIET_BIT = 32'h00400000;
    localparam logic [31:0] POS_2P31  = 32'h4F000000;
    localparam logic [31:0] NEG_2P31  = 32'hCF000000;
    localparam logic [8:0]  EXP_BIAS  = 9'd127;

    typedef struct packed {
        logic        last;
        logic [8:0]  ebits;
        logic [31:0] val;
    } side_t;

    typedef struct packed {
        logic               sp;
        logic [31:0]        sp_bits;
        logic               sign;
        logic signed [11:0] exp;
        logic [47:0]        mant;
    } fpre_t;

    typedef struct packed {
        logic [31:0] nf;
        logic [8:0]  ebits;
    } trunc_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (&x[30:23]) && !(|x[22:0]);
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return !(|x[30:0]);
    endfunction

    function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
        logic res;
        if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b)))
            res = 1'b0;
        else if (a[31] != b[31])
            res = a[31];
        else if (!a[31])
            res = a[30:0] < b[30:0];
        else
            res = a[30:0] > b[30:0];
        return res;
    endfunction

    function automatic logic [31:0] clamp_neg(input logic [31:0] s);
        logic [31:0] x;
        x = {~s[31], s[30:0]};
        x = flt(NEG_LIMIT, x) ? x : NEG_LIMIT;
        x = flt(x, POS_LIMIT) ? x : POS_LIMIT;
        return x;
    endfunction

    function automatic trunc_t trunc_split(input logic [31:0] p);
        trunc_t      t;
        logic [7:0]  e;
        logic [31:0] mag;
        logic [31:0] n;
        logic [4:0]  sh;
        e = p[30:23];
        mag = '0;
        sh = '0;
        if (is_nan(p)) begin
            n = '0;
            t.nf = '0;
        end else if (e >= 8'd158) begin
            n = p[31] ? 32'h80000000 : 32'h7FFFFFFF;
            t.nf = p[31] ? NEG_2P31 : POS_2P31;
        end else if (e < 8'd127) begin
            n = '0;
            t.nf = '0;
        end else begin
            mag = {8'b0, 1'b1, p[22:0]};
            if (e >= 8'd150) begin
                sh = 5'(e - 8'd150);
                mag = mag << sh;
                t.nf = p;
            end else begin
                sh = 5'(8'd150 - e);
                mag = mag >> sh;
                t.nf = {p[31:23], p[22:0] & ~((23'd1 << sh) - 23'd1)};
            end
            n = p[31] ? (32'd0 - mag) : mag;
        end
        t.ebits = n[8:0] + EXP_BIAS;
        return t;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] m);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < 48; i++) begin
            if (m[i])
                c = 6'(47 - i);
        end
        return c;
    endfunction

    function automatic fpre_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
        fpre_t      f;
        logic [7:0] ea;
        logic [7:0] eb;
        f.sign = a[31] ^ b[31];
        f.sp = 1'b1;
        f.sp_bits = '0;
        f.exp = '0;
        f.mant = '0;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        if (is_nan(a))
            f.sp_bits = a | QUIET_BIT;
        else if (is_nan(b))
            f.sp_bits = b | QUIET_BIT;
        else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            f.sp_bits = QNAN_DEF;
        else if (is_inf(a) || is_inf(b))
            f.sp_bits = {f.sign, 8'hFF, 23'b0};
        else if (is_zero(a) || is_zero(b))
            f.sp_bits = {f.sign, 31'b0};
        else begin
            f.sp = 1'b0;
            f.mant = {|a[30:23], a[22:0]} * {|b[30:23], b[22:0]};
            f.exp = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
        end
        return f;
    endfunction

    function automatic fpre_t fadd_pre(input logic [31:0] a, input logic [31:0] b);
        fpre_t       f;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [47:0] bm;
        logic [47:0] sm;
        logic        stk;
        f.sp = 1'b1;
        f.sp_bits = '0;
        f.sign = 1'b0;
        f.exp = '0;
        f.mant = '0;
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d = eb - es;
        bm = {1'b0, |big[30:23], big[22:0], 23'b0};
        sm = {1'b0, |sml[30:23], sml[22:0], 23'b0};
        if (d >= 8'd48) begin
            stk = |sm;
            sm = '0;
        end else begin
            stk = |(sm & ((48'd1 << d) - 48'd1));
            sm = sm >> d;
        end
        sm[0] = sm[0] | stk;
        if (is_nan(a))
            f.sp_bits = a | QUIET_BIT;
        else if (is_nan(b))
            f.sp_bits = b | QUIET_BIT;
        else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
            f.sp_bits = QNAN_DEF;
        else if (is_inf(a))
            f.sp_bits = a;
        else if (is_inf(b))
            f.sp_bits = b;
        else begin
            f.sp = 1'b0;
            f.mant = (a[31] == b[31]) ? (bm + sm) : (bm - sm);
            f.sign = (f.mant == 48'd0) ? (a[31] & b[31]) : big[31];
            f.exp = $signed({4'b0, eb}) + 12'sd1;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_pack(input fpre_t f);
        logic [31:0]        res;
        logic [47:0]        m;
        logic signed [12:0] e;
        logic [12:0]        sh;
        logic [5:0]         lz;
        logic               stk;
        logic               up;
        logic [24:0]        r25;
        logic [23:0]        r;
        stk = 1'b0;
        lz = lzc48(f.mant);
        m = f.mant << lz;
        e = {f.exp[11], f.exp} - $signed({7'b0, lz});
        if (e < 13'sd1) begin
            sh = 13'(13'sd1 - e);
            if (sh >= 13'd48) begin
                stk = |m;
                m = '0;
            end else begin
                stk = |(m & ((48'd1 << sh) - 48'd1));
                m = m >> sh;
            end
            e = 13'sd1;
        end
        up = m[23] && ((|m[22:0]) || stk || m[24]);
        r25 = {1'b0, m[47:24]} + {24'b0, up};
        if (r25[24]) begin
            r = r25[24:1];
            e = e + 13'sd1;
        end else begin
            r = r25[23:0];
        end
        if (f.sp)
            res = f.sp_bits;
        else if (f.mant == 48'd0)
            res = {f.sign, 31'b0};
        else if (e >= 13'sd255)
            res = {f.sign, 8'hFF, 23'b0};
        else
            res = {f.sign, (r[23] ? e[7:0] : 8'h00), r[22:0]};
        return res;
    endfunction

endpackage

// ----- hdl/fenp_in_if.sv -----
// ---------------------------------------------------------------------------
// fenp_in_if
// input item channel: source value and end-of-array mark
// ---------------------------------------------------------------------------
interface fenp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_bits;
    logic        last_in;

    modport source (output valid, output src_bits, output last_in, input ready);
    modport sink (input valid, input src_bits, input last_in, output ready);
endinterface

// ----- hdl/fenp_out_if.sv -----
// ---------------------------------------------------------------------------
// fenp_out_if
// result item channel: exp approximation and end-of-array mark
// ---------------------------------------------------------------------------
interface fenp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] exp_bits;
    logic        last_out;

    modport source (output valid, output exp_bits, output last_out, input ready);
    modport sink (input valid, input exp_bits, input last_out, output ready);
endinterface

// ----- hdl/fenp_cfg_if.sv -----
// ---------------------------------------------------------------------------
// fenp_cfg_if
// register write channel: index and data
// ---------------------------------------------------------------------------
interface fenp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/fenp_fmul.sv -----
// ---------------------------------------------------------------------------
// fenp_fmul
// two-stage single-precision multiplier, round to nearest even
// ---------------------------------------------------------------------------
module fenp_fmul
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [31:0]     a,
    input  logic [31:0]     b,
    input  fenp_pkg::side_t in_side,
    output logic            out_valid,
    output logic [31:0]     y,
    output fenp_pkg::side_t out_side
);
    import fenp_pkg::*;

    logic        va_reg;
    fpre_t       pre_reg;
    fpre_t       pre_next;
    side_t       sa_reg;
    logic        vb_reg;
    logic [31:0] y_reg;
    logic [31:0] y_next;
    side_t       sb_reg;

    assign pre_next = fmul_pre(a, b);
    assign y_next   = round_pack(pre_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg <= pre_next;
            sa_reg  <= in_side;
            y_reg   <= y_next;
            sb_reg  <= sa_reg;
        end
    end

    assign out_valid = vb_reg;
    assign y         = y_reg;
    assign out_side  = sb_reg;
endmodule

// ----- hdl/fenp_fadd.sv -----
// ---------------------------------------------------------------------------
// fenp_fadd
// two-stage single-precision adder: align and add, then normalise and round
// ---------------------------------------------------------------------------
module fenp_fadd
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [31:0]     a,
    input  logic [31:0]     b,
    input  fenp_pkg::side_t in_side,
    output logic            out_valid,
    output logic [31:0]     y,
    output fenp_pkg::side_t out_side
);
    import fenp_pkg::*;

    logic        va_reg;
    fpre_t       pre_reg;
    fpre_t       pre_next;
    side_t       sa_reg;
    logic        vb_reg;
    logic [31:0] y_reg;
    logic [31:0] y_next;
    side_t       sb_reg;

    assign pre_next = fadd_pre(a, b);
    assign y_next   = round_pack(pre_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg <= pre_next;
            sa_reg  <= in_side;
            y_reg   <= y_next;
            sb_reg  <= sa_reg;
        end
    end

    assign out_valid = vb_reg;
    assign y         = y_reg;
    assign out_side  = sb_reg;
endmodule

// ----- hdl/fast_exp_neg_approx.sv -----
// ---------------------------------------------------------------------------
// fast_exp_neg_approx
// pipelined single-precision approximation of exp(-s)
// ---------------------------------------------------------------------------
// src carries one item per handshake: src_bits (float s) and last_in.
// dst returns one item per input, in order: exp_bits and last_out.
// cfg writes the eight float registers (ln2, 1/ln2, c0..c5) by index;
// it is always ready and should only be used while no item is in flight.
// the path from src acceptance to dst valid has one clamp stage,
// one truncation stage and fourteen float units of two stages each
// (range reduction multiplies and subtract, five horner multiply/add
// pairs, final scale multiply).
// one item per cycle unless dst stalls; all stages advance together.
// when dst stalls with a result waiting, every stage holds and src.ready
// drops; bubbles in the pipe still move so src.ready stays high.
// reset empties the pipeline and loads the default coefficients.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fast_exp_neg_approx
(
    input  logic        clk,
    input  logic        rst_n,
    fenp_in_if.sink     src,
    fenp_out_if.source  dst,
    fenp_cfg_if.sink    cfg
);
    import fenp_pkg::*;

    logic        adv;
    logic [31:0] cfg_reg [NUM_CFG];

    logic        v0_reg;
    side_t       side0_reg;
    side_t       side0_next;

    logic        v1;
    logic [31:0] p1;
    side_t       side1;

    logic        v2_reg;
    logic [31:0] nf2_reg;
    side_t       side2_reg;
    trunc_t      tr_next;

    logic        v3;
    logic [31:0] prod3;
    side_t       side3;
    logic [31:0] prod3_neg;

    logic        v4;
    logic [31:0] r4;
    side_t       side4;

    logic        hv [HORNER_STEPS+1];
    logic [31:0] hp [HORNER_STEPS+1];
    side_t       hs [HORNER_STEPS+1];
    logic        mv [HORNER_STEPS];
    logic [31:0] mp [HORNER_STEPS];
    side_t       ms [HORNER_STEPS];

    side_t       side_f;

    assign adv       = !dst.valid || dst.ready;
    assign src.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            cfg_reg[cfg.index] <= cfg.data;
        end
    end

    // clamp stage
    assign side0_next = '{last: src.last_in, ebits: '0, val: clamp_neg(src.src_bits)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= src.valid;
            v2_reg <= v1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side0_reg <= side0_next;
            nf2_reg   <= tr_next.nf;
            side2_reg <= '{last: side1.last, ebits: tr_next.ebits, val: side1.val};
        end
    end

    fenp_fmul u_mul_n
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v0_reg),
        .a         (side0_reg.val),
        .b         (cfg_reg[CFG_INV_LN2]),
        .in_side   (side0_reg),
        .out_valid (v1),
        .y         (p1),
        .out_side  (side1)
    );

    // integer part and exponent field
    assign tr_next = trunc_split(p1);

    fenp_fmul u_mul_ln2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .a         (nf2_reg),
        .b         (cfg_reg[CFG_LN2]),
        .in_side   (side2_reg),
        .out_valid (v3),
        .y         (prod3),
        .out_side  (side3)
    );

    // subtraction as addition of the negated product, nan kept as is
    assign prod3_neg = is_nan(prod3) ? prod3 : {~prod3[31], prod3[30:0]};

    fenp_fadd u_sub_r
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v3),
        .a         (side3.val),
        .b         (prod3_neg),
        .in_side   (side3),
        .out_valid (v4),
        .y         (r4),
        .out_side  (side4)
    );

    assign hv[0] = v4;
    assign hp[0] = cfg_reg[CFG_C5];
    assign hs[0] = '{last: side4.last, ebits: side4.ebits, val: r4};

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        fenp_fmul u_mul
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (hv[k]),
            .a         (hp[k]),
            .b         (hs[k].val),
            .in_side   (hs[k]),
            .out_valid (mv[k]),
            .y         (mp[k]),
            .out_side  (ms[k])
        );

        fenp_fadd u_add
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (mv[k]),
            .a         (mp[k]),
            .b         (cfg_reg[CFG_C4 - k]),
            .in_side   (ms[k]),
            .out_valid (hv[k+1]),
            .y         (hp[k+1]),
            .out_side  (hs[k+1])
        );
    end

    fenp_fmul u_mul_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (hv[HORNER_STEPS]),
        .a         ({hs[HORNER_STEPS].ebits, 23'b0}),
        .b         (hp[HORNER_STEPS]),
        .in_side   (hs[HORNER_STEPS]),
        .out_valid (dst.valid),
        .y         (dst.exp_bits),
        .out_side  (side_f)
    );

    assign dst.last_out = side_f.last;

    `ASSERT_IMPL(a_ready_only_on_stall, !src.ready, dst.valid && !dst.ready)
    `ASSERT_NEXT(a_enter_first_stage, src.valid && src.ready, v0_reg)
    `ASSERT_NEXT(a_stall_freezes_pipe, !src.ready, $stable(v0_reg) && $stable(v2_reg))
endmodule
